// ----- rtl/core/hpq_pkg.sv -----
// ----------------------------------------------------------------------------
// hpq_pkg
// shared constants, codes and link types of the heap queue and its level cells
// ----------------------------------------------------------------------------
package hpq_pkg;

    localparam int CAPACITY  = 1024;
    localparam int KEY_W     = 32;
    localparam int OUT_CNT_W = 11;
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int LEVELS    = CNT_W;
    localparam int NCELL     = LEVELS - 1;
    localparam int IDX_W     = LEVELS - 1;
    localparam int ROW_W     = (IDX_W > 1) ? IDX_W - 1 : 1;
    localparam int LVL_W     = $clog2(LEVELS);

    localparam logic OPC_INSERT = 1'b0;
    localparam logic OPC_DELETE = 1'b1;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    typedef enum logic [1:0] {
        OP_INS,
        OP_FETCH,
        OP_SIFT
    } hpq_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_WAIT,
        ST_DONE
    } hpq_state_t;

    // token travelling down the chain
    typedef struct packed {
        logic             valid;
        hpq_op_t          op;
        logic [KEY_W-1:0] key;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] node;
        logic [LVL_W-1:0] rem;
    } hpq_tok_t;

    // write of a key into the level above
    typedef struct packed {
        logic             valid;
        logic [IDX_W-1:0] idx;
        logic [KEY_W-1:0] key;
    } hpq_wb_t;

    // completion and fetch return toward the controller
    typedef struct packed {
        logic             done;
        logic             fetch;
        logic [KEY_W-1:0] key;
    } hpq_ret_t;

    typedef struct packed {
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
        logic [1:0]       wr_en;
        logic [ROW_W-1:0] wr_row;
        logic [KEY_W-1:0] wr_key;
    } hpq_req_t;

    function automatic logic [LVL_W-1:0] msb_pos(input logic [CNT_W-1:0] v);
        logic [LVL_W-1:0] pos;
        pos = '0;
        for (int i = 0; i < CNT_W; i++) begin
            if (v[i]) begin
                pos = LVL_W'(i);
            end
        end
        return pos;
    endfunction

endpackage

// ----- rtl/core/binary_max_heap_queue.sv -----
// ----------------------------------------------------------------------------
// binary_max_heap_queue
// max-priority queue of unsigned keys as a binary heap, a cell per non-root level
// ----------------------------------------------------------------------------
// The queue takes one item at a time: opcode 0 inserts s_key, opcode 1 removes
// the largest key. Each item gives one result with status (0 ok, 1 full on
// insert, 2 empty on delete), the largest key held afterwards (0 when empty)
// and the key count. The root sits in a register; every lower heap level is a
// cell with its own ram of sibling pairs, and work walks the chain of cells
// one level at a time. Insert does a read and a compare in each level's ram on
// the path to the new slot. Delete first walks the cells one level at a time to
// fetch the last key, then does a read and a compare per level while it sinks.
// Full, empty, single-key and first-insert items go straight from accept to the
// done state. The next item is taken in the idle state that follows the loading
// of a result, and can be accepted while the previous result waits.
module binary_max_heap_queue (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_opcode,
    input  logic [hpq_pkg::KEY_W-1:0]        s_key,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [1:0]                       m_status,
    output logic [hpq_pkg::KEY_W-1:0]        m_top_key,
    output logic [hpq_pkg::OUT_CNT_W-1:0]    m_entry_count
);
    import hpq_pkg::*;

    hpq_state_t       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [KEY_W-1:0] root_reg, root_next;
    logic [1:0]       status_reg, status_next;
    hpq_tok_t         inj_reg, inj_next;

    logic                 m_valid_reg, m_valid_next;
    logic [1:0]           m_status_reg;
    logic [KEY_W-1:0]     m_top_reg;
    logic [OUT_CNT_W-1:0] m_count_reg;

    hpq_tok_t         tok   [NCELL+1];
    hpq_wb_t          wb_up [NCELL+1];
    hpq_ret_t         ret   [NCELL];
    hpq_req_t         req   [NCELL];
    logic [2*KEY_W-1:0] rdata [NCELL];

    logic             s_accept, load_out;
    logic             is_full, is_empty, is_one;
    logic             done_any, fetch_any;
    logic [KEY_W-1:0] fetch_key;
    logic [CNT_W-1:0] ins_t;
    logic [LVL_W-1:0] ins_d, del_d;

    assign tok[0]       = inj_reg;
    assign wb_up[NCELL] = '0;

    for (genvar k = 0; k < NCELL; k++) begin : g_level
        localparam int LVL_NODES = (k + 2 == LEVELS) ? CAPACITY + 1 - (1 << (k + 1))
                                                     : (1 << (k + 1));
        localparam int ROWS = (LVL_NODES + 1) / 2;
        localparam int AW   = (ROWS > 1) ? $clog2(ROWS) : 1;

        hpq_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .cnt     (count_reg),
            .tok_in  (tok[k]),
            .tok_out (tok[k+1]),
            .wb_in   (wb_up[k+1]),
            .wb_out  (wb_up[k]),
            .ret     (ret[k]),
            .mem_req (req[k]),
            .rd_data (rdata[k])
        );

        hpq_ram #(
            .DEPTH  (ROWS),
            .LANE_W (KEY_W),
            .LANES  (2)
        ) u_ram (
            .clk     (aclk),
            .wr_en   (req[k].wr_en),
            .wr_addr (req[k].wr_row[AW-1:0]),
            .wr_data ({req[k].wr_key, req[k].wr_key}),
            .rd_en   (req[k].rd_en),
            .rd_addr (req[k].rd_row[AW-1:0]),
            .rd_data (rdata[k])
        );
    end

    always_comb begin
        done_any  = 1'b0;
        fetch_any = 1'b0;
        fetch_key = '0;
        for (int k = 0; k < NCELL; k++) begin
            done_any  = done_any | ret[k].done;
            fetch_any = fetch_any | ret[k].fetch;
            fetch_key = fetch_key | (ret[k].fetch ? ret[k].key : '0);
        end
    end

    assign is_full  = (count_reg == CNT_W'(CAPACITY));
    assign is_empty = (count_reg == '0);
    assign is_one   = (count_reg == CNT_W'(1));
    assign ins_t    = count_reg + 1'b1;
    assign ins_d    = msb_pos(ins_t);
    assign del_d    = msb_pos(count_reg);

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_opcode == OPC_INSERT) begin
                        state_next = (is_full || is_empty) ? ST_DONE : ST_WAIT;
                    end else begin
                        state_next = (is_empty || is_one) ? ST_DONE : ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                if (fetch_any) begin
                    state_next = is_one ? ST_DONE : ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (done_any) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // handshake outputs
    always_comb begin
        s_ready  = (state_reg == ST_IDLE);
        load_out = (state_reg == ST_DONE) && (!m_valid_reg || m_ready);
        s_accept = s_valid && s_ready;
    end

    always_comb begin
        count_next  = count_reg;
        root_next   = root_reg;
        status_next = status_reg;
        inj_next    = '0;

        if (wb_up[0].valid) begin
            root_next = wb_up[0].key;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    status_next = STAT_OK;
                    if (s_opcode == OPC_INSERT) begin
                        if (is_full) begin
                            status_next = STAT_FULL;
                        end else if (is_empty) begin
                            root_next  = s_key;
                            count_next = ins_t;
                        end else begin
                            count_next    = ins_t;
                            inj_next.valid = 1'b1;
                            inj_next.op   = OP_INS;
                            inj_next.idx  = '0;
                            inj_next.node = ins_t;
                            inj_next.rem  = ins_d - 1'b1;
                            if (root_reg < s_key) begin
                                root_next    = s_key;
                                inj_next.key = root_reg;
                            end else begin
                                inj_next.key = s_key;
                            end
                        end
                    end else begin
                        if (is_empty) begin
                            status_next = STAT_EMPTY;
                        end else if (is_one) begin
                            count_next = '0;
                        end else begin
                            count_next     = count_reg - 1'b1;
                            inj_next.valid = 1'b1;
                            inj_next.op    = OP_FETCH;
                            inj_next.key   = '0;
                            inj_next.idx   = '0;
                            inj_next.node  = count_reg;
                            inj_next.rem   = del_d - 1'b1;
                        end
                    end
                end
            end
            ST_FETCH: begin
                if (fetch_any) begin
                    if (is_one) begin
                        root_next = fetch_key;
                    end else begin
                        inj_next.valid = 1'b1;
                        inj_next.op    = OP_SIFT;
                        inj_next.key   = fetch_key;
                        inj_next.idx   = '0;
                        inj_next.node  = CNT_W'(1);
                        inj_next.rem   = '0;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            inj_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            inj_reg     <= inj_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        root_reg   <= root_next;
        status_reg <= status_next;
        if (load_out) begin
            m_status_reg <= status_reg;
            m_top_reg    <= is_empty ? '0 : root_reg;
            m_count_reg  <= OUT_CNT_W'(count_reg);
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_status      = m_status_reg;
    assign m_top_key     = m_top_reg;
    assign m_entry_count = m_count_reg;

endmodule

// ----- rtl/core/hpq_ram.sv -----
// ----------------------------------------------------------------------------
// hpq_ram
// simple dual-port ram with per-lane write enables and registered read
// ----------------------------------------------------------------------------
module hpq_ram #(
    parameter  int DEPTH  = 2,
    parameter  int LANE_W = 32,
    parameter  int LANES  = 2,
    localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                    clk,
    input  logic [LANES-1:0]        wr_en,
    input  logic [AW-1:0]           wr_addr,
    input  logic [LANES*LANE_W-1:0] wr_data,
    input  logic                    rd_en,
    input  logic [AW-1:0]           rd_addr,
    output logic [LANES*LANE_W-1:0] rd_data
);

    logic [LANES*LANE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        for (int i = 0; i < LANES; i++) begin
            if (wr_en[i]) begin
                mem[wr_addr][i*LANE_W +: LANE_W] <= wr_data[i*LANE_W +: LANE_W];
            end
        end
    end

    always_ff @(posedge clk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ----- rtl/core/hpq_cell.sv -----
// ----------------------------------------------------------------------------
// hpq_cell
// one heap level: holds sibling pairs of its level, passes insert, fetch and sift tokens down a step
// ----------------------------------------------------------------------------
module hpq_cell (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [hpq_pkg::CNT_W-1:0]      cnt,
    input  hpq_pkg::hpq_tok_t              tok_in,
    output hpq_pkg::hpq_tok_t              tok_out,
    input  hpq_pkg::hpq_wb_t               wb_in,
    output hpq_pkg::hpq_wb_t               wb_out,
    output hpq_pkg::hpq_ret_t              ret,
    output hpq_pkg::hpq_req_t              mem_req,
    input  logic [2*hpq_pkg::KEY_W-1:0]    rd_data
);
    import hpq_pkg::*;

    hpq_tok_t         st_reg, st_next;
    hpq_tok_t         tok_reg, tok_next;
    hpq_wb_t          wb_reg, wb_next;
    hpq_ret_t         ret_reg, ret_next;
    logic             in_bit, st_bit;
    logic [KEY_W-1:0] left_key, right_key, st_key, pick_key;
    logic             right_ok, pick_r;
    logic [CNT_W:0]   child_n;
    logic [CNT_W+1:0] grand_n;

    assign left_key  = rd_data[KEY_W-1:0];
    assign right_key = rd_data[2*KEY_W-1:KEY_W];
    assign in_bit    = tok_in.node[tok_in.rem];
    assign st_bit    = st_reg.node[st_reg.rem];
    assign st_key    = st_bit ? right_key : left_key;
    assign right_ok  = ({st_reg.node, 1'b1} <= {1'b0, cnt});
    assign pick_r    = right_ok && (left_key < right_key);
    assign pick_key  = pick_r ? right_key : left_key;
    assign child_n   = {st_reg.node, pick_r};
    assign grand_n   = {child_n, 1'b0};

    always_comb begin
        st_next  = '0;
        tok_next = '0;
        wb_next  = '0;
        ret_next = '0;
        mem_req  = '0;

        // key moving up from the level below
        if (wb_in.valid) begin
            mem_req.wr_en  = {wb_in.idx[0], ~wb_in.idx[0]};
            mem_req.wr_row = ROW_W'(wb_in.idx >> 1);
            mem_req.wr_key = wb_in.key;
        end

        if (tok_in.valid) begin
            unique case (tok_in.op)
                OP_INS: begin
                    if (tok_in.rem == '0) begin
                        mem_req.wr_en  = {in_bit, ~in_bit};
                        mem_req.wr_row = ROW_W'(tok_in.idx);
                        mem_req.wr_key = tok_in.key;
                        ret_next.done  = 1'b1;
                    end else begin
                        mem_req.rd_en  = 1'b1;
                        mem_req.rd_row = ROW_W'(tok_in.idx);
                        st_next        = tok_in;
                    end
                end
                OP_FETCH: begin
                    if (tok_in.rem == '0) begin
                        mem_req.rd_en  = 1'b1;
                        mem_req.rd_row = ROW_W'(tok_in.idx);
                        st_next        = tok_in;
                    end else begin
                        tok_next     = tok_in;
                        tok_next.idx = IDX_W'({tok_in.idx, in_bit});
                        tok_next.rem = tok_in.rem - 1'b1;
                    end
                end
                OP_SIFT: begin
                    mem_req.rd_en  = 1'b1;
                    mem_req.rd_row = ROW_W'(tok_in.idx);
                    st_next        = tok_in;
                end
                default: ;
            endcase
        end

        if (st_reg.valid) begin
            unique case (st_reg.op)
                OP_INS: begin
                    tok_next     = st_reg;
                    tok_next.idx = IDX_W'({st_reg.idx, st_bit});
                    tok_next.rem = st_reg.rem - 1'b1;
                    if (st_key < st_reg.key) begin
                        mem_req.wr_en  = {st_bit, ~st_bit};
                        mem_req.wr_row = ROW_W'(st_reg.idx);
                        mem_req.wr_key = st_reg.key;
                        tok_next.key   = st_key;
                    end
                end
                OP_FETCH: begin
                    ret_next.fetch = 1'b1;
                    ret_next.key   = st_key;
                end
                OP_SIFT: begin
                    wb_next.valid = 1'b1;
                    wb_next.idx   = st_reg.idx;
                    if (st_reg.key < pick_key) begin
                        wb_next.key = pick_key;
                        if (grand_n <= {2'b00, cnt}) begin
                            tok_next      = st_reg;
                            tok_next.idx  = IDX_W'({st_reg.idx, pick_r});
                            tok_next.node = child_n[CNT_W-1:0];
                        end else begin
                            mem_req.wr_en  = {pick_r, ~pick_r};
                            mem_req.wr_row = ROW_W'(st_reg.idx);
                            mem_req.wr_key = st_reg.key;
                            ret_next.done  = 1'b1;
                        end
                    end else begin
                        wb_next.key   = st_reg.key;
                        ret_next.done = 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= '0;
            tok_reg <= '0;
            wb_reg  <= '0;
            ret_reg <= '0;
        end else begin
            st_reg  <= st_next;
            tok_reg <= tok_next;
            wb_reg  <= wb_next;
            ret_reg <= ret_next;
        end
    end

    assign tok_out = tok_reg;
    assign wb_out  = wb_reg;
    assign ret     = ret_reg;

endmodule
